### rtl/spl_pkg.sv
// shared types and constants for the sorted position lookup block
package spl_pkg;

  localparam int CHROM_W = 8;
  localparam int CHUNK_W = 16;
  localparam int POS_W   = 31;

  // one reference table entry as stored in memory
  typedef struct packed {
    logic [CHROM_W-1:0] chrom;
    logic [CHUNK_W-1:0] chunk;
    logic [POS_W-1:0]   pos;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // input item function codes
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // which key field the shared comparator looks at
  typedef enum logic [1:0] {
    KEY_CHROM = 2'd0,
    KEY_CHUNK = 2'd1,
    KEY_POS   = 2'd2
  } key_sel_t;

  // control from the sequencer to the comparator
  typedef struct packed {
    key_sel_t sel;
    logic     upper;
  } cmp_ctrl_t;

  // comparator answer back to the sequencer
  typedef struct packed {
    logic go_right;
    logic equal;
  } cmp_res_t;

endpackage

### rtl/spl_if.sv
// handshake channel interfaces for the input items and the results
interface spl_in_if;
  import spl_pkg::*;
  logic               valid;
  logic               ready;
  logic               func;
  logic [CHROM_W-1:0] chrom;
  logic [CHUNK_W-1:0] chunk;
  logic [POS_W-1:0]   position;

  modport source (output valid, func, chrom, chunk, position, input ready);
  modport sink   (input valid, func, chrom, chunk, position, output ready);
endinterface

interface spl_out_if #(
  parameter int IDX_W = 13
);
  logic             valid;
  logic             ready;
  logic             found;
  logic [IDX_W-1:0] match_index;

  modport source (output valid, found, match_index, input ready);
  modport sink   (input valid, found, match_index, output ready);
endinterface

### rtl/sorted_position_lookup.sv
// sorted position lookup: table loader, search sequencer and result register
//
// Input channel in_ch carries func, chrom, chunk and position. A load beat
// (func 0) appends one entry and gives no result; loads beyond the table
// depth are dropped. A query beat (func 1) gives exactly one result beat on
// out_ch: found and the 1-based match_index, 0 when no match.
// cfg_we/cfg_wdata set chunk_mode and force the next query to search again.
// A query whose group (chrom, plus chunk in chunk mode) is still held runs
// one lower-bound search over the current range, with at most
// log2(range)+1 probes. A new group adds two searches over the loaded table
// for the chrom bounds and, in chunk mode, two more over that chrom range.
// Every probe goes through the single read port of the table ram and one
// shared key comparator. in_ch.ready is high only while no query is in work.
// The result sits in an output register, so a new beat is taken while it
// waits; a query finishes only once that register is free. Reset empties
// the table and clears chunk_mode, the held group and the output.
module sorted_position_lookup
  import spl_pkg::*;
#(
  parameter int TABLE_DEPTH = 4096
) (
  input  logic         clk,
  input  logic         rst_n,
  spl_in_if.sink       in_ch,
  spl_out_if.source    out_ch,
  input  logic         cfg_we,
  input  logic         cfg_wdata
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_PROBE = 5'b00010,
    S_CMP   = 5'b00100,
    S_CHECK = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  typedef enum logic [4:0] {
    PH_CLO = 5'b00001,
    PH_CHI = 5'b00010,
    PH_KLO = 5'b00100,
    PH_KHI = 5'b01000,
    PH_POS = 5'b10000
  } phase_t;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;

  logic [CW-1:0] lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt;
  logic [CW-1:0] b_r, b_nxt, e_r, e_nxt;
  logic [CW-1:0] cursor_r, cursor_nxt, range_end_r, range_end_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CHROM_W-1:0] group_chrom_r, group_chrom_nxt;
  logic [CHUNK_W-1:0] group_chunk_r, group_chunk_nxt;
  logic group_valid_r, group_valid_nxt;
  logic chunk_mode_r, chunk_mode_nxt;
  logic [CHROM_W-1:0] q_chrom_r, q_chrom_nxt;
  logic [CHUNK_W-1:0] q_chunk_r, q_chunk_nxt;
  logic [POS_W-1:0] q_pos_r, q_pos_nxt;
  logic res_found_r, res_found_nxt;
  logic [CW-1:0] res_idx_r, res_idx_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_found_r, out_found_nxt;
  logic [CW-1:0] out_idx_r, out_idx_nxt;

  logic          in_beat, do_load, need_search, probe_live, out_free;
  logic [CW-1:0] span, mid;
  logic [AW-1:0] raddr;
  entry_t        wr_entry, rd_entry;
  cmp_ctrl_t     cmp_ctrl;
  cmp_res_t      cmp_res;

  assign in_ch.ready = state_r == S_IDLE;
  assign in_beat     = in_ch.valid && in_ch.ready;
  assign do_load     = in_beat && in_ch.func == FUNC_LOAD && count_r < DEPTH_C;

  assign span       = hi_r - lo_r;
  assign mid        = lo_r + (span >> 1);
  assign probe_live = lo_r < hi_r;
  // when the search is over, lo is the bound and the last read fetches it
  assign raddr      = probe_live ? mid[AW-1:0] : lo_r[AW-1:0];

  assign wr_entry.chrom = in_ch.chrom;
  assign wr_entry.chunk = in_ch.chunk;
  assign wr_entry.pos   = in_ch.position;

  spl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (do_load),
    .waddr (count_r[AW-1:0]),
    .wdata (wr_entry),
    .raddr (raddr),
    .rdata (rd_entry)
  );

  always_comb begin
    unique case (phase_r)
      PH_CLO:  cmp_ctrl = '{sel: KEY_CHROM, upper: 1'b0};
      PH_CHI:  cmp_ctrl = '{sel: KEY_CHROM, upper: 1'b1};
      PH_KLO:  cmp_ctrl = '{sel: KEY_CHUNK, upper: 1'b0};
      PH_KHI:  cmp_ctrl = '{sel: KEY_CHUNK, upper: 1'b1};
      default: cmp_ctrl = '{sel: KEY_POS,   upper: 1'b0};
    endcase
  end

  spl_key_cmp u_cmp (
    .ctrl    (cmp_ctrl),
    .entry   (rd_entry),
    .q_chrom (q_chrom_r),
    .q_chunk (q_chunk_r),
    .q_pos   (q_pos_r),
    .res     (cmp_res)
  );

  assign need_search = !group_valid_r || in_ch.chrom != group_chrom_r ||
                       (chunk_mode_r && in_ch.chunk != group_chunk_r);
  assign out_free    = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt       = state_r;
    phase_nxt       = phase_r;
    lo_nxt          = lo_r;
    hi_nxt          = hi_r;
    mid_nxt         = mid_r;
    b_nxt           = b_r;
    e_nxt           = e_r;
    cursor_nxt      = cursor_r;
    range_end_nxt   = range_end_r;
    count_nxt       = count_r;
    group_chrom_nxt = group_chrom_r;
    group_chunk_nxt = group_chunk_r;
    group_valid_nxt = group_valid_r;
    chunk_mode_nxt  = chunk_mode_r;
    q_chrom_nxt     = q_chrom_r;
    q_chunk_nxt     = q_chunk_r;
    q_pos_nxt       = q_pos_r;
    res_found_nxt   = res_found_r;
    res_idx_nxt     = res_idx_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_found_nxt   = out_found_r;
    out_idx_nxt     = out_idx_r;

    if (cfg_we) begin
      chunk_mode_nxt  = cfg_wdata;
      group_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (do_load) begin
          count_nxt       = count_r + 1'b1;
          group_valid_nxt = 1'b0;
        end
        if (in_beat && in_ch.func == FUNC_QUERY) begin
          q_chrom_nxt = in_ch.chrom;
          q_chunk_nxt = in_ch.chunk;
          q_pos_nxt   = in_ch.position;
          if (need_search) begin
            phase_nxt = PH_CLO;
            lo_nxt    = '0;
            hi_nxt    = count_r;
            state_nxt = S_PROBE;
          end else if (cursor_r > range_end_r) begin
            res_found_nxt = 1'b0;
            res_idx_nxt   = '0;
            state_nxt     = S_DONE;
          end else begin
            phase_nxt = PH_POS;
            lo_nxt    = cursor_r;
            hi_nxt    = range_end_r;
            state_nxt = S_PROBE;
          end
        end
      end
      S_PROBE: begin
        if (probe_live) begin
          mid_nxt   = mid;
          state_nxt = S_CMP;
        end else begin
          unique case (phase_r)
            PH_CLO: begin
              b_nxt     = lo_r;
              hi_nxt    = count_r;
              phase_nxt = PH_CHI;
            end
            PH_CHI: begin
              if (chunk_mode_r) begin
                e_nxt     = lo_r;
                hi_nxt    = lo_r;
                lo_nxt    = b_r;
                phase_nxt = PH_KLO;
              end else begin
                cursor_nxt      = b_r;
                range_end_nxt   = lo_r;
                group_chrom_nxt = q_chrom_r;
                group_chunk_nxt = q_chunk_r;
                group_valid_nxt = 1'b1;
                lo_nxt          = b_r;
                hi_nxt          = lo_r;
                phase_nxt       = PH_POS;
              end
            end
            PH_KLO: begin
              b_nxt     = lo_r;
              hi_nxt    = e_r;
              phase_nxt = PH_KHI;
            end
            PH_KHI: begin
              cursor_nxt      = b_r;
              range_end_nxt   = lo_r;
              group_chrom_nxt = q_chrom_r;
              group_chunk_nxt = q_chunk_r;
              group_valid_nxt = 1'b1;
              lo_nxt          = b_r;
              hi_nxt          = lo_r;
              phase_nxt       = PH_POS;
            end
            default: begin
              if (lo_r < range_end_r) begin
                // cursor moves to the lower bound, then check it is exact
                cursor_nxt = lo_r;
                state_nxt  = S_CHECK;
              end else begin
                res_found_nxt = 1'b0;
                res_idx_nxt   = '0;
                state_nxt     = S_DONE;
              end
            end
          endcase
        end
      end
      S_CMP: begin
        if (cmp_res.go_right) begin
          lo_nxt = mid_r + 1'b1;
        end else begin
          hi_nxt = mid_r;
        end
        state_nxt = S_PROBE;
      end
      S_CHECK: begin
        res_found_nxt = cmp_res.equal;
        res_idx_nxt   = cmp_res.equal ? cursor_r + 1'b1 : '0;
        state_nxt     = S_DONE;
      end
      default: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found_r;
          out_idx_nxt   = res_idx_r;
          state_nxt     = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      phase_r       <= PH_CLO;
      cursor_r      <= '0;
      range_end_r   <= '0;
      count_r       <= '0;
      group_chrom_r <= '0;
      group_chunk_r <= '0;
      group_valid_r <= 1'b0;
      chunk_mode_r  <= 1'b0;
      out_valid_r   <= 1'b0;
      lo_r          <= '0;
      hi_r          <= '0;
      mid_r         <= '0;
    end else begin
      state_r       <= state_nxt;
      phase_r       <= phase_nxt;
      cursor_r      <= cursor_nxt;
      range_end_r   <= range_end_nxt;
      count_r       <= count_nxt;
      group_chrom_r <= group_chrom_nxt;
      group_chunk_r <= group_chunk_nxt;
      group_valid_r <= group_valid_nxt;
      chunk_mode_r  <= chunk_mode_nxt;
      out_valid_r   <= out_valid_nxt;
      lo_r          <= lo_nxt;
      hi_r          <= hi_nxt;
      mid_r         <= mid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    b_r         <= b_nxt;
    e_r         <= e_nxt;
    q_chrom_r   <= q_chrom_nxt;
    q_chunk_r   <= q_chunk_nxt;
    q_pos_r     <= q_pos_nxt;
    res_found_r <= res_found_nxt;
    res_idx_r   <= res_idx_nxt;
    out_found_r <= out_found_nxt;
    out_idx_r   <= out_idx_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.found       = out_found_r;
  assign out_ch.match_index = out_idx_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("entry count past table depth");

  a_search_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PROBE || state_r == S_CMP) |-> lo_r <= hi_r && hi_r <= count_r)
    else $error("search window out of order");

  a_mid_inside: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CMP |-> mid_r >= lo_r && mid_r < hi_r)
    else $error("probe index outside search window");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    group_valid_r |-> cursor_r <= range_end_r && range_end_r <= count_r)
    else $error("cursor beyond held range");

  a_hit_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && res_found_r) |-> res_idx_r == cursor_r + 1'b1)
    else $error("match index does not follow cursor");

endmodule

### rtl/spl_ram.sv
// generic single write port, single read port ram with registered read
module spl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/spl_key_cmp.sv
// shared key comparator used by every binary search probe
module spl_key_cmp
  import spl_pkg::*;
(
  input  cmp_ctrl_t          ctrl,
  input  entry_t             entry,
  input  logic [CHROM_W-1:0] q_chrom,
  input  logic [CHUNK_W-1:0] q_chunk,
  input  logic [POS_W-1:0]   q_pos,
  output cmp_res_t           res
);

  logic [POS_W-1:0] key;
  logic [POS_W-1:0] val;
  logic             lt;

  always_comb begin
    unique case (ctrl.sel)
      KEY_CHROM: begin
        key = POS_W'(entry.chrom);
        val = POS_W'(q_chrom);
      end
      KEY_CHUNK: begin
        key = POS_W'(entry.chunk);
        val = POS_W'(q_chunk);
      end
      default: begin
        key = entry.pos;
        val = q_pos;
      end
    endcase
  end

  assign lt           = key < val;
  assign res.equal    = key == val;
  // lower bound moves right past smaller keys, upper bound past equal ones too
  assign res.go_right = ctrl.upper ? (lt | res.equal) : lt;

endmodule
